>>> hw/rtl/oets_pkg.sv
package oets_pkg;

  localparam int unsigned ELEM_W = 32;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } request_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sorted_value;
    logic                     end_of_run;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // shift a new element in at cell 0
    logic phase_en;   // run one compare-exchange phase
    logic phase_odd;  // 1: pairs (1,2),(3,4)...  0: pairs (0,1),(2,3)...
    logic emit;       // shift the head out to the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;       // an element stands behind the head cell
  } status_t;

endpackage

>>> hw/rtl/oets_ctrl.sv
module oets_ctrl #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             req_last,
  input  oets_pkg::status_t status,
  output logic             busy,
  output oets_pkg::cmd_t   cmd
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SORT,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] phase;
  logic [CNT_W-1:0] count_next;
  logic             accept;

  assign busy       = (state != S_LOAD);
  assign accept     = start && !busy;
  assign count_next = count + CNT_W'(1);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.phase_en  = (state == S_SORT);
    cmd.phase_odd = phase[0];
    cmd.emit      = (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_next;
            phase <= '0;
            if (req_last || count_next == CNT_W'(MAX_ELEMENTS)) begin
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (phase == count - CNT_W'(1)) begin
            phase <= '0;
            state <= S_EMIT;
          end else begin
            phase <= phase + CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (!status.more) begin
            count <= '0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_phase_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT) |-> (phase < count))
    else $error("sort phase beyond run length");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (phase == '0))
    else $error("phase counter not cleared while loading");
`endif

endmodule

>>> hw/rtl/oets_datapath.sv
module oets_datapath #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  oets_pkg::cmd_t    cmd,
  input  oets_pkg::request_t request,
  output oets_pkg::status_t status,
  output oets_pkg::result_t result,
  output logic              result_valid
);

  // row of cells; each cell reads only its neighbors
  logic signed [oets_pkg::ELEM_W-1:0] cells      [MAX_ELEMENTS];
  logic signed [oets_pkg::ELEM_W-1:0] cells_next [MAX_ELEMENTS];
  logic        [MAX_ELEMENTS-1:0]     valid;

  assign status.more = valid[1];

  // one odd-even phase; pairs of one parity are disjoint
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cells_next[i] = cells[i];
    end
    for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
      if ((((j % 2) == 1) == cmd.phase_odd) && valid[j+1] && (cells[j] > cells[j+1])) begin
        cells_next[j]   = cells[j+1];
        cells_next[j+1] = cells[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cells[0] <= request.value;
      for (int i = 1; i < MAX_ELEMENTS; i++) begin
        cells[i] <= cells[i-1];
      end
    end else if (cmd.phase_en) begin
      cells <= cells_next;
    end else if (cmd.emit) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        valid <= {valid[MAX_ELEMENTS-2:0], 1'b1};
      end else if (cmd.emit) begin
        valid <= {1'b0, valid[MAX_ELEMENTS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.sorted_value <= cells[0];
      result.end_of_run   <= !valid[1];
    end
  end

`ifndef SYNTHESIS
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.end_of_run) |=> result_valid)
    else $error("gap inside an emitted run");

  a_load_fills_head: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> valid[0])
    else $error("head cell empty after load");
`endif

endmodule

>>> hw/rtl/odd_even_transposition_sorter.sv
// Odd-even transposition sorter, runs of up to MAX_ELEMENTS signed 32-bit values.
// Load: one request per cycle while busy is low; the run ends on last or a full store.
// Sort: n phases of parallel compare-exchange, one per cycle; then emit, one per cycle.
// busy stays high through the sort and emit steps; the first result follows the last sort phase.
// A new run is not taken until the last one is emitted; results cannot be stalled by the receiver.
// Reset (rst, synchronous, active high) empties the store and returns to loading.
module odd_even_transposition_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  oets_pkg::request_t request,
  output oets_pkg::result_t  result,
  output logic               result_valid
);

  // Controller and datapath talk only through these two groups.
  oets_pkg::cmd_t    cmd;
  oets_pkg::status_t status;

  // Controller: tracks run length and phase count, sequences load/sort/emit.
  // A request is taken when start is high and busy is low.
  oets_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_last (request.last),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Datapath: a row of cells with per-cell valid bits.
  // New elements shift in at cell 0; each phase compare-exchanges neighbor
  // pairs among valid cells; emit shifts the smallest out of cell 0 into the
  // result register, flagging end_of_run when no element remains behind it.
  oets_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request      (request),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

>>> tb/sort_result_checker.sv
module sort_result_checker #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  oets_pkg::request_t request,
  input  oets_pkg::result_t  result,
  input  logic               result_valid,
  input  logic               drain_done,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen
);

  logic signed [oets_pkg::ELEM_W-1:0] run_vals [MAX_ELEMS];
  int unsigned                        held;
  oets_pkg::result_t                  sorted_q [$];
  bit                                 leftovers_done;

  initial begin
    mismatches     = 0;
    pending        = 0;
    results_seen   = 0;
    held           = 0;
    leftovers_done = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // n phases of compare-exchange; even phases start at pair (0,1), odd at (1,2)
  task automatic order_run(input int n);
    logic signed [oets_pkg::ELEM_W-1:0] swap;
    for (int ph = 0; ph < n; ph++) begin
      for (int j = ph % 2; j + 1 < n; j += 2) begin
        if (run_vals[j] > run_vals[j+1]) begin
          swap          = run_vals[j];
          run_vals[j]   = run_vals[j+1];
          run_vals[j+1] = swap;
        end
      end
    end
  endtask

  task automatic queue_sorted_run(input int n);
    oets_pkg::result_t r;
    order_run(n);
    for (int i = 0; i < n; i++) begin
      r.sorted_value = run_vals[i];
      r.end_of_run   = (i == n - 1);
      sorted_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    oets_pkg::result_t exp_r;
    if (rst) begin
      held = 0;
    end else begin
      if (result_valid) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d end_of_run=%0b",
                                    result.sorted_value, result.end_of_run));
        end else begin
          exp_r = sorted_q.pop_front();
          if (result.sorted_value !== exp_r.sorted_value)
            report_mismatch($sformatf("sorted_value got %0d want %0d",
                                      result.sorted_value, exp_r.sorted_value));
          if (result.end_of_run !== exp_r.end_of_run)
            report_mismatch($sformatf("end_of_run got %0b want %0b (value %0d)",
                                      result.end_of_run, exp_r.end_of_run,
                                      exp_r.sorted_value));
        end
      end
      if (start && !busy) begin
        run_vals[held] = request.value;
        held++;
        // run closes on the last mark or when the store is full
        if (request.last || held == MAX_ELEMS) begin
          queue_sorted_run(held);
          held = 0;
        end
      end
    end
    if (drain_done && !leftovers_done) begin
      leftovers_done = 1;
      while (sorted_q.size() != 0) begin
        exp_r = sorted_q.pop_front();
        report_mismatch($sformatf("result never arrived: value=%0d end_of_run=%0b",
                                  exp_r.sorted_value, exp_r.end_of_run));
      end
    end
    pending = sorted_q.size();
  end

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int unsigned MAX_ELEMS    = 64;
  // covers busy through sort and emit of a full run after the final request, plus slack
  localparam int          DRAIN_CYCLES = 2 * MAX_ELEMS + 8;
  localparam int          WAIT_LIMIT   = 8 * MAX_ELEMS + 50;
  localparam int          RANDOM_ITEMS = 140;
  localparam int          IDLE_PCT     = 31;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  oets_pkg::request_t request;
  oets_pkg::result_t  result;
  logic               result_valid;
  logic               drain_done;

  int mismatches;
  int pending;
  int results_seen;

  // stimulus bookkeeping
  int items_sent;
  int runs_sent;
  int full_runs;
  bit quiet;   // set during the stretch where the sender never idles

  odd_even_transposition_sorter #(
    .MAX_ELEMENTS(MAX_ELEMS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result      (result),
    .result_valid(result_valid)
  );

  // Predicts the sorted runs from the accepted requests and checks every result.
  sort_result_checker #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result      (result),
    .result_valid(result_valid),
    .drain_done  (drain_done),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the sorter hangs or drops results.
  initial begin
    #2_000_000;
    $display("timeout: sorter stopped making progress");
    $display("CHECKS FAILED");
    $finish;
  end

  // Sender idle: start low, payload is noise the block must ignore; k gives the length.
  task automatic idle_cycles(input int k);
    oets_pkg::request_t noise;
    repeat (k) begin
      noise.value = $urandom;
      noise.last  = $urandom_range(0, 1);
      @(negedge clk);
      start   <= 1'b0;
      request <= noise;
    end
  endtask

  // One request: optional random gap first, then hold start until busy is low
  // at a rising edge. start stays high into the next call, so back-to-back
  // requests get a single assignment per falling edge.
  task automatic send_value(input logic signed [oets_pkg::ELEM_W-1:0] v,
                            input logic is_last);
    oets_pkg::request_t req;
    req.value = v;
    req.last  = is_last;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
      idle_cycles(1);
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    // busy read right after the edge is its pre-edge value
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Mix of full-range values, a narrow band for duplicates, and the extremes.
  function automatic logic signed [oets_pkg::ELEM_W-1:0] pick_value();
    logic signed [oets_pkg::ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      6, 7:    v = $signed($urandom_range(0, 8)) - 4;
      8:       v = 32'sh8000_0000;
      9:       v = 32'sh7fff_ffff;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Wait until every expected result has been emitted, or until WAIT_LIMIT is reached.
  task automatic wait_drained();
    int w;
    w = 0;
    do begin
      @(negedge clk);
      w++;
    end while (pending != 0 && w < WAIT_LIMIT);
  endtask

  initial begin
    int len;
    int rand_items;
    int run_no;
    bit mark_end;

    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    drain_done = 1'b0;
    items_sent = 0;
    runs_sent  = 0;
    full_runs  = 0;
    quiet      = 1'b0;
    rand_items = 0;
    run_no     = 0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // ---- directed runs ----
    // single-element runs at both extremes
    send_value(32'sh8000_0000, 1'b1);
    send_value(32'sh7fff_ffff, 1'b1);
    // equal pair: must not be exchanged, order of equal keys kept
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b1);
    // extremes, zero, +/-1 and alternating bit patterns in one run
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shaaaa_aaaa, 1'b0);
    send_value(32'sh8000_0001, 1'b1);
    // strictly descending input; shifting in at cell 0 leaves it already in order in the cells
    for (int i = 4; i >= 0; i--)
      send_value(i, i == 0);
    // duplicates around a larger value
    send_value(-32'sd7, 1'b0);
    send_value(32'sd3, 1'b0);
    send_value(-32'sd7, 1'b1);
    runs_sent += 6;

    // Hold off until the sorter has emitted everything so far.
    @(negedge clk);
    start <= 1'b0;
    wait_drained();

    // ---- random runs ----
    // Mostly short runs; one run fills the store with no last mark, one fills
    // it with last on the final element if the item budget reaches that run, and a few are medium length.
    while (rand_items < RANDOM_ITEMS) begin
      mark_end = 1'b1;
      if (run_no == 1) begin
        len      = MAX_ELEMS;
        mark_end = 1'b0;
      end else if (run_no == 4) begin
        len = MAX_ELEMS;
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(11, 40);
      end else begin
        len = $urandom_range(1, 10);
      end
      if (len == MAX_ELEMS)
        full_runs++;
      for (int i = 0; i < len; i++) begin
        // long gap-free stretch in the middle of the random part
        quiet = (rand_items >= 40 && rand_items < 110);
        send_value(pick_value(), (i == len - 1) ? mark_end : 1'b0);
        rand_items++;
      end
      run_no++;
      runs_sent++;
    end

    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    // checker flags anything still expected on the next edge
    drain_done <= 1'b1;
    @(negedge clk);

    $display("covered %0d runs (%0d filling the store), %0d requests, %0d results checked",
             runs_sent, full_runs, items_sent, results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/oets_pkg.sv
hw/rtl/oets_ctrl.sv
hw/rtl/oets_datapath.sv
hw/rtl/odd_even_transposition_sorter.sv
tb/sort_result_checker.sv
tb/testbench.sv
